// ----- rtl/wft_pkg.sv -----
package wft_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int WORD_CHARS_DEF  = 48;

    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 8;
    localparam int CNT_W      = 16;
    localparam int LEN_W      = 6;
    localparam int POS_W      = 16;
    localparam int UNQ_W      = 9;
    localparam int TOT_W      = 20;
    localparam int OUT_DATA_W = 80;

    // bit positions of the result word
    localparam int OB_IDX  = 0;
    localparam int OB_NEW  = 8;
    localparam int OB_CNT  = 9;
    localparam int OB_FULL = 48;

    localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
    localparam logic [CHAR_W-1:0] CH_UC_A  = 8'd65;
    localparam logic [CHAR_W-1:0] CH_UC_Z  = 8'd90;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'd97;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'd122;
    localparam logic [CHAR_W-1:0] CH_CASE  = 8'h20;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_RD,
        S_CMP,
        S_HIT_RD,
        S_HIT_WR,
        S_INS,
        S_FIN
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_row;
        logic idx_inc;
        logic rd_cnt;
        logic wr_hit;
        logic ins;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic close;
        logic tbl_empty;
        logic match;
        logic last_idx;
        logic out_busy;
    } t_stat;

endpackage

// ----- rtl/wft_ctrl.sv -----
module wft_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  wft_pkg::t_stat i_stat,
    output wft_pkg::t_cmd  o_cmd
);
    import wft_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid && i_stat.close) n_state = S_LOOK;
            end
            S_LOOK: begin
                n_state = i_stat.tbl_empty ? S_INS : S_RD;
            end
            S_RD: n_state = S_CMP;
            S_CMP: begin
                priority if (i_stat.match) n_state = S_HIT_RD;
                else if (i_stat.last_idx)  n_state = S_INS;
                else                       n_state = S_RD;
            end
            S_HIT_RD: n_state = S_HIT_WR;
            S_HIT_WR: n_state = S_FIN;
            S_INS:    n_state = S_FIN;
            S_FIN: begin
                if (!i_stat.out_busy) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
            end
            S_LOOK:   o_cmd = '0;
            S_RD:     o_cmd.rd_row = 1'b1;
            S_CMP:    o_cmd.idx_inc = !i_stat.match && !i_stat.last_idx;
            S_HIT_RD: o_cmd.rd_cnt = 1'b1;
            S_HIT_WR: o_cmd.wr_hit = 1'b1;
            S_INS:    o_cmd.ins = 1'b1;
            S_FIN:    o_cmd.load_out = !i_stat.out_busy;
            default:  o_cmd = '0;
        endcase
    end

endmodule

// ----- rtl/wft_dp.sv -----
module wft_dp #(
    parameter int MAX_ENTRIES = wft_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_CHARS  = wft_pkg::WORD_CHARS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wft_pkg::t_cmd                   i_cmd,
    output wft_pkg::t_stat                  o_stat,
    input  logic [wft_pkg::CHAR_W-1:0]      i_char,
    input  logic                            i_last,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wft_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic                            o_m_tlast
);
    import wft_pkg::*;

    localparam int LW    = $clog2(WORD_CHARS + 1);
    localparam int BW    = (WORD_CHARS > 1) ? $clog2(WORD_CHARS) : 1;
    localparam int EW    = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW    = $clog2(MAX_ENTRIES + 1);
    localparam int ROW_W = WORD_CHARS * CHAR_W + LW;

    // open token
    logic [CHAR_W-1:0] r_buf [WORD_CHARS];
    logic [LW-1:0]     r_len;
    logic              r_open, r_cut;
    logic [POS_W-1:0]  r_pos;

    // word under lookup
    logic [LW-1:0]     r_wlen;
    logic              r_wcut, r_wlast;
    logic [POS_W-1:0]  r_wpos;

    logic [EW-1:0]     r_idx;
    logic [CW-1:0]     r_ecnt;
    logic [TOT_W-1:0]  r_total;

    // table: row = {length, letters}
    logic [ROW_W-1:0]  r_rows [MAX_ENTRIES];
    logic [ROW_W-1:0]  r_row_q;
    logic [CNT_W-1:0]  r_counts [MAX_ENTRIES];
    logic [CNT_W-1:0]  r_cnt_q;

    logic [EW-1:0]     r_res_slot;
    logic              r_res_new, r_res_full;
    logic [CNT_W-1:0]  r_res_cnt;

    logic                  r_out_valid, r_out_last;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic              is_delim, is_upper, is_letter, wr_buf, open_a, cut_a, close;
    logic [CHAR_W-1:0] lc;
    logic [LW-1:0]     len0, len_a;
    logic [POS_W-1:0]  pos_a;
    logic              match, tbl_full;
    logic [ROW_W-1:0]  w_row;
    logic [CNT_W-1:0]  cnt_inc;
    logic [TOT_W-1:0]  total_inc;

    assign is_delim  = (i_char == CH_SPACE) || (i_char == CH_TAB) || (i_char == CH_LF);
    assign is_upper  = (i_char >= CH_UC_A) && (i_char <= CH_UC_Z);
    assign lc        = is_upper ? (i_char | CH_CASE) : i_char;
    assign is_letter = (lc >= CH_LC_A) && (lc <= CH_LC_Z);

    always_comb begin
        open_a = r_open;
        len0   = r_open ? r_len : '0;
        len_a  = r_len;
        cut_a  = r_cut;
        pos_a  = r_pos;
        wr_buf = 1'b0;
        if (!is_delim) begin
            open_a = 1'b1;
            len_a  = len0;
            cut_a  = r_open ? r_cut : 1'b0;
            if (!r_open && r_pos != '1) pos_a = r_pos + POS_W'(1);
            if (is_letter) begin
                if (len0 < LW'(WORD_CHARS)) begin
                    wr_buf = 1'b1;
                    len_a  = len0 + LW'(1);
                end else begin
                    cut_a = 1'b1;
                end
            end
        end
    end

    assign close = (is_delim || i_last) && open_a && (len_a != '0);

    always_comb begin
        match = (r_row_q[ROW_W-1 -: LW] == r_wlen);
        for (int j = 0; j < WORD_CHARS; j++) begin
            if (LW'(j) < r_wlen && r_row_q[j*CHAR_W +: CHAR_W] != r_buf[j]) match = 1'b0;
        end
    end

    always_comb begin
        w_row = '0;
        for (int j = 0; j < WORD_CHARS; j++) begin
            w_row[j*CHAR_W +: CHAR_W] = r_buf[j];
        end
        w_row[ROW_W-1 -: LW] = r_wlen;
    end

    assign tbl_full  = (r_ecnt == CW'(MAX_ENTRIES));
    assign cnt_inc   = (r_cnt_q == '1) ? r_cnt_q : r_cnt_q + CNT_W'(1);
    assign total_inc = (r_total == '1) ? r_total : r_total + TOT_W'(1);

    assign o_stat.close     = close;
    assign o_stat.tbl_empty = (r_ecnt == '0);
    assign o_stat.match     = match;
    assign o_stat.last_idx  = ((CW'(r_idx) + CW'(1)) == r_ecnt);
    assign o_stat.out_busy  = r_out_valid && !i_m_tready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && wr_buf) r_buf[len0[BW-1:0]] <= lc;
        if (i_cmd.accept && close) begin
            r_wlen  <= len_a;
            r_wcut  <= cut_a;
            r_wpos  <= pos_a;
            r_wlast <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= '0;
            r_open  <= 1'b0;
            r_cut   <= 1'b0;
            r_pos   <= '0;
            r_idx   <= '0;
            r_ecnt  <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.accept) begin
                r_idx <= '0;
                if (is_delim || i_last) begin
                    r_open <= 1'b0;
                    r_len  <= '0;
                    r_cut  <= 1'b0;
                end else begin
                    r_open <= open_a;
                    r_len  <= len_a;
                    r_cut  <= cut_a;
                end
                r_pos <= i_last ? '0 : pos_a;
            end
            if (i_cmd.idx_inc) r_idx <= r_idx + EW'(1);
            if (i_cmd.wr_hit) r_total <= total_inc;
            if (i_cmd.ins && !tbl_full) begin
                r_ecnt  <= r_ecnt + CW'(1);
                r_total <= total_inc;
            end
        end
    end

    // table memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ins && !tbl_full) r_rows[r_ecnt[EW-1:0]] <= w_row;
        if (i_cmd.rd_row) r_row_q <= r_rows[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hit) begin
            r_counts[r_idx] <= cnt_inc;
        end else if (i_cmd.ins && !tbl_full) begin
            r_counts[r_ecnt[EW-1:0]] <= CNT_W'(1);
        end
        if (i_cmd.rd_cnt) r_cnt_q <= r_counts[r_idx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_hit) begin
            r_res_slot <= r_idx;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
            r_res_cnt  <= cnt_inc;
        end else if (i_cmd.ins) begin
            r_res_slot <= tbl_full ? '0 : r_ecnt[EW-1:0];
            r_res_new  <= !tbl_full;
            r_res_full <= tbl_full;
            r_res_cnt  <= tbl_full ? '0 : CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_out) r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_last <= r_wlast;
            r_out_data <= {2'b00, r_total, UNQ_W'(r_ecnt), r_res_full, r_wcut, r_wpos,
                           LEN_W'(r_wlen), r_res_cnt, r_res_new, IDX_W'(r_res_slot)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// ----- rtl/word_frequency_table.sv -----
// channel  dir  tdata (low bit up)                                    tlast
// s        in   char_code[7:0]                                        text_end
// m        out  entry_index, is_new, occurrence_count, word_length,   last_of_text
//               token_position, was_truncated, table_full,
//               unique_words, total_words, 2 zero pad bits
//
// A byte that does not close a word is taken in S_IDLE. A word end passes S_LOOK,
// then per stored entry compared one row read of the table memory (S_RD) and one
// compare (S_CMP), then S_HIT_RD and S_HIT_WR or S_INS to update, S_FIN to post.
// Synchronous active-low reset; no clearing pass, the entry count bounds lookups.
// Bytes are taken while a result waits on m; a closing byte stalls at the
// end of its lookup until the previous result is taken.
module word_frequency_table #(
    parameter int MAX_ENTRIES = wft_pkg::MAX_ENTRIES_DEF,
    parameter int WORD_CHARS  = wft_pkg::WORD_CHARS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [wft_pkg::CHAR_W-1:0]      i_s_tdata,   // char_code
    input  logic                            i_s_tlast,   // text_end
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [wft_pkg::OUT_DATA_W-1:0]  o_m_tdata,   // see table above
    output logic                            o_m_tlast    // last_of_text
);
    import wft_pkg::*;

    t_cmd  w_cmd;
    t_stat w_stat;

    wft_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    wft_dp #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .WORD_CHARS  (WORD_CHARS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_char     (i_s_tdata),
        .i_last     (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // dropped word reports slot 0, not new, count 0
    a_full_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[OB_FULL] |->
            o_m_tdata[OB_NEW] == 1'b0 && o_m_tdata[OB_IDX +: IDX_W] == '0 &&
            o_m_tdata[OB_CNT +: CNT_W] == '0)
        else $error("table_full result carries entry data");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[OB_FULL] |-> o_m_tdata[OB_CNT +: CNT_W] != '0)
        else $error("stored word with zero count");

    a_new_count_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[OB_NEW] |-> o_m_tdata[OB_CNT +: CNT_W] == CNT_W'(1))
        else $error("new entry count not one");

    a_ready_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !(w_cmd.rd_row || w_cmd.wr_hit || w_cmd.ins))
        else $error("lookup activity while taking bytes");

endmodule

// ----- tb/sv/tb_word_frequency_table.sv -----
`timescale 1ns / 100ps

module tb_word_frequency_table;
    import wft_pkg::*;

    localparam int N_SLOTS = MAX_ENTRIES_DEF;
    localparam int N_CHARS = WORD_CHARS_DEF;
    localparam int VOCAB_N = 30;

    typedef struct packed {
        logic [IDX_W-1:0] entry_index;
        logic             is_new;
        logic [CNT_W-1:0] occurrence_count;
        logic [LEN_W-1:0] word_length;
        logic [POS_W-1:0] token_position;
        logic             was_truncated;
        logic             table_full;
        logic [UNQ_W-1:0] unique_words;
        logic [TOT_W-1:0] total_words;
        logic             last_of_text;
    } t_word_res;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;
        t_word_res         res;
    } t_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [CHAR_W-1:0]      i_s_tdata;   // char_code
    logic                   i_s_tlast;   // text_end
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_DATA_W-1:0]  o_m_tdata;   // entry_index, is_new, occurrence_count,
                                         // word_length, token_position,
                                         // was_truncated, table_full,
                                         // unique_words, total_words, pad
    logic                   o_m_tlast;   // last_of_text

    word_frequency_table i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // word-count model state
    logic [7:0]  cur_word [N_CHARS];
    int          cur_len;
    bit          tok_open;
    bit          tok_cut;
    int          tok_pos;
    logic [7:0]  tbl_letters [N_SLOTS][N_CHARS];
    int          tbl_len [N_SLOTS];
    int          tbl_cnt [N_SLOTS];
    int          n_entries;
    int          n_occur;

    t_word_res   expected_words[$];
    int          errors;
    int          words_seen;
    int          bytes_sent;
    int          full_hits;
    int          cut_hits;
    int          gap_pct;
    int          stall_pct;
    int          hold_left;

    logic [7:0]  vocab_ch [VOCAB_N][12];
    int          vocab_len [VOCAB_N];

    function automatic bit close_word(bit last, output t_word_res r);
        int hit;
        hit = -1;
        r = '0;
        if (!tok_open || cur_len == 0) begin
            tok_open = 0;
            cur_len = 0;
            tok_cut = 0;
            return 0;
        end
        for (int i = 0; i < n_entries && hit < 0; i++) begin
            if (tbl_len[i] == cur_len) begin
                bit same;
                same = 1;
                for (int k = 0; k < cur_len; k++)
                    if (tbl_letters[i][k] != cur_word[k]) same = 0;
                if (same) hit = i;
            end
        end
        if (hit >= 0) begin
            if (tbl_cnt[hit] < 65535) tbl_cnt[hit]++;
            r.entry_index = hit[IDX_W-1:0];
            r.occurrence_count = tbl_cnt[hit][CNT_W-1:0];
            if (n_occur < 1048575) n_occur++;
        end else if (n_entries < N_SLOTS) begin
            for (int k = 0; k < cur_len; k++) tbl_letters[n_entries][k] = cur_word[k];
            tbl_len[n_entries] = cur_len;
            tbl_cnt[n_entries] = 1;
            r.entry_index = n_entries[IDX_W-1:0];
            r.is_new = 1'b1;
            r.occurrence_count = CNT_W'(1);
            n_entries++;
            if (n_occur < 1048575) n_occur++;
        end else begin
            r.table_full = 1'b1;
        end
        r.word_length = cur_len[LEN_W-1:0];
        r.token_position = tok_pos[POS_W-1:0];
        r.was_truncated = tok_cut;
        r.unique_words = n_entries[UNQ_W-1:0];
        r.total_words = n_occur[TOT_W-1:0];
        r.last_of_text = last;
        tok_open = 0;
        cur_len = 0;
        tok_cut = 0;
        return 1;
    endfunction

    function automatic bit count_byte(logic [7:0] c, bit last, output t_word_res r);
        bit got;
        got = 0;
        r = '0;
        if (c == CH_SPACE || c == CH_TAB || c == CH_LF) begin
            got = close_word(last, r);
        end else begin
            if (!tok_open) begin
                tok_open = 1;
                cur_len = 0;
                tok_cut = 0;
                if (tok_pos < 65535) tok_pos++;
            end
            if (c >= CH_UC_A && c <= CH_UC_Z) c = c + CH_CASE;
            if (c >= CH_LC_A && c <= CH_LC_Z) begin
                if (cur_len < N_CHARS) begin
                    cur_word[cur_len] = c;
                    cur_len++;
                end else begin
                    tok_cut = 1;
                end
            end
            if (last) got = close_word(1'b1, r);
        end
        if (last) begin
            tok_open = 0;
            cur_len = 0;
            tok_cut = 0;
            tok_pos = 0;
        end
        return got;
    endfunction

    task automatic send_byte(logic [7:0] c, bit last, bit typed = 0,
                             t_word_res typed_res = '0);
        t_word_res r;
        bit        got;
        bit        done;
        if ($urandom_range(99) < gap_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= c;
        i_s_tlast  <= last;
        done = 0;
        while (!done) begin
            @(posedge i_clk);
            done = o_s_tready;
        end
        got = count_byte(c, last, r);
        if (typed) expected_words.push_back(typed_res);
        else if (got) expected_words.push_back(r);
        bytes_sent++;
        // valid stays up; the next word or drain decides what comes next
        @(negedge i_clk);
    endtask

    task automatic send_delim(bit last);
        int k;
        k = $urandom_range(2);
        send_byte(k == 0 ? CH_SPACE : (k == 1 ? CH_TAB : CH_LF), last);
    endtask

    task automatic send_token_mix(int budget);
        int stop_at;
        int kind;
        int n;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(99);
            if (kind < 65) begin
                n = $urandom_range(VOCAB_N - 1);
                for (int k = 0; k < vocab_len[n]; k++) begin
                    logic [7:0] c;
                    c = vocab_ch[n][k];
                    if ($urandom_range(1)) c = c - CH_CASE;
                    send_byte(c, 0);
                end
            end else if (kind < 73) begin
                // overlong: shares a prefix so truncated words collide
                n = $urandom_range(55, 44);
                for (int k = 0; k < n; k++) send_byte(8'(CH_LC_A + (k % 3)), 0);
            end else if (kind < 86) begin
                n = $urandom_range(5, 1);
                for (int k = 0; k < n; k++) begin
                    logic [7:0] c;
                    c = 8'($urandom_range(255));
                    if (c == CH_SPACE || c == CH_TAB || c == CH_LF) c = 8'd33;
                    send_byte(c, 0);
                end
            end else begin
                n = $urandom_range(VOCAB_N - 1);
                for (int k = 0; k < vocab_len[n]; k++) begin
                    send_byte(vocab_ch[n][k], 0);
                    if ($urandom_range(3) == 0) send_byte(8'($urandom_range(64, 33)), 0);
                end
            end
            if ($urandom_range(99) < 5) send_byte(8'(CH_LC_A + $urandom_range(25)), 1);
            else send_delim($urandom_range(99) < 4);
        end
    endtask

    task automatic drain;
        i_s_tvalid <= 1'b0;
        do @(negedge i_clk); while (expected_words.size() != 0);
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            t_word_res got;
            t_word_res want;
            got = {o_m_tdata[7:0], o_m_tdata[8], o_m_tdata[24:9], o_m_tdata[30:25],
                   o_m_tdata[46:31], o_m_tdata[47], o_m_tdata[48], o_m_tdata[57:49],
                   o_m_tdata[77:58], o_m_tlast};
            words_seen++;
            if (got.table_full) full_hits++;
            if (got.was_truncated) cut_hits++;
            if (expected_words.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word result %p", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10) $display("word mismatch\n  exp %p\n  got %p", want, got);
                end
            end
        end
    end

    initial begin
        #50_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        t_row rows[$];
        int   fill_n;
        int   extra_full;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_m_tready = 1'b0;
        errors = 0;
        words_seen = 0;
        bytes_sent = 0;
        full_hits = 0;
        cut_hits = 0;
        gap_pct = 0;
        stall_pct = 0;
        hold_left = 0;
        cur_len = 0;
        tok_open = 0;
        tok_cut = 0;
        tok_pos = 0;
        n_entries = 0;
        n_occur = 0;
        for (int i = 0; i < VOCAB_N; i++) begin
            vocab_len[i] = $urandom_range(8, 1);
            for (int k = 0; k < 12; k++) vocab_ch[i][k] = 8'(CH_LC_A + $urandom_range(25));
        end
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: idx, new, cnt, len, pos, cut, full, unique, total, last
        rows = '{
            '{"A",   1, 1, '{0, 1, 1, 1, 1, 0, 0, 1, 1, 1}},
            '{"Z",   0, 0, '0},
            '{"z",   0, 0, '0},
            '{CH_SPACE, 0, 1, '{1, 1, 1, 2, 1, 0, 0, 2, 2, 0}},
            '{"a",   0, 0, '0},
            '{"!",   0, 0, '0},
            '{CH_TAB, 0, 1, '{0, 0, 2, 1, 2, 0, 0, 2, 3, 0}},
            '{"1",   0, 0, '0},
            '{CH_LF, 0, 0, '0},
            '{8'd0,  0, 0, '0},
            '{"b",   0, 0, '0},
            '{8'd255, 1, 1, '{2, 1, 1, 1, 4, 0, 0, 3, 4, 1}},
            '{CH_SPACE, 1, 0, '0},
            '{"m",   0, 0, '0},
            '{"Z",   0, 0, '0},
            '{CH_LF, 1, 1, '{3, 1, 1, 2, 1, 0, 0, 4, 5, 1}},
            '{"@",   0, 0, '0},
            '{"a",   0, 0, '0},
            '{"z",   1, 0, '0}
        };
        foreach (rows[i]) send_byte(rows[i].ch, rows[i].last, rows[i].typed, rows[i].res);
        drain();

        // long receiver hold-off while bytes keep coming
        hold_left = 400;
        send_token_mix(200);
        drain();
        gap_pct = 52;
        send_token_mix(200);
        drain();
        gap_pct = 0;
        stall_pct = 52;
        send_token_mix(200);
        drain();
        gap_pct = 21;
        stall_pct = 21;
        send_token_mix(200);

        // fill the table, then offer fresh words to a full table
        fill_n = 0;
        extra_full = 0;
        while (extra_full < 12) begin
            if (n_entries >= N_SLOTS) extra_full++;
            send_byte("q", 0);
            send_byte(8'(CH_LC_A + fill_n % 26), 0);
            send_byte(8'(CH_LC_A + (fill_n / 26) % 26), 0);
            send_delim(0);
            fill_n++;
        end
        send_token_mix(60);
        send_byte("w", 1);
        drain();
        repeat (700) @(negedge i_clk);

        $display("sent %0d bytes, checked %0d word results (%0d truncated, %0d table full)",
                 bytes_sent, words_seen, cut_hits, full_hits);
        $display("table ended with %0d entries, %0d occurrences", n_entries, n_occur);
        if (errors == 0 && expected_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("mismatches %0d, still expected %0d", errors, expected_words.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/wft_pkg.sv
rtl/wft_ctrl.sv
rtl/wft_dp.sv
rtl/word_frequency_table.sv
tb/sv/tb_word_frequency_table.sv
